// ===== sv/prsm_pkg.sv =====
`timescale 1ns / 1ps
// Package for the polar ring source mapper: widths, pipeline depths,
// payload structs and the CORDIC arctangent table. Depends on nothing.
package prsm_pkg;

   // Arithmetic settings.
   localparam int ANGLE_BITS       = 16;
   localparam int CORDIC_STEPS     = 16;
   localparam int RADIUS_FRAC_BITS = 4;
   localparam int GUARD_BITS       = 16;
   localparam int ATAN_LEN         = 24;

   // Field widths.
   localparam int COORD_W = 10;
   localparam int VIEW_W  = 11;
   localparam int INNER_W = 10;
   localparam int OUTER_W = 11;
   localparam int SRC_W   = 13;
   localparam int OUT_W   = 12;
   localparam int DATA_W  = 32;
   localparam int ADDR_W  = 5;

   // Derived datapath widths.
   localparam int OFS_W      = VIEW_W;
   localparam int D2_W       = 2 * OFS_W - 1;
   localparam int N_W        = D2_W + 2 * RADIUS_FRAC_BITS;
   localparam int ROOT_W     = (N_W + 1) / 2;
   localparam int NUM_W      = OUTER_W + RADIUS_FRAC_BITS;
   localparam int VEC_W      = OFS_W + GUARD_BITS + 3;
   localparam int COL_PROD_W = ANGLE_BITS + SRC_W;
   localparam int ROW_PROD_W = NUM_W + SRC_W;
   localparam int QUO_W      = OUT_W;

   // Pipeline depths.
   localparam int MID_STAGES   = (CORDIC_STEPS > ROOT_W) ? CORDIC_STEPS : ROOT_W;
   localparam int SCALE_STAGES = QUO_W + 2;
   localparam int TOTAL_STAGES = 1 + MID_STAGES + SCALE_STAGES;

   localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

   localparam logic [ANGLE_BITS-1:0] ANGLE_QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
   localparam logic [ANGLE_BITS-1:0] ANGLE_HALF    = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
   localparam logic [ANGLE_BITS-1:0] ANGLE_3QUART  = ANGLE_HALF | ANGLE_QUARTER;

   // Register map.
   typedef enum logic [2:0] {
      REG_VIEW_SIZE     = 3'd0,
      REG_INNER_RADIUS  = 3'd1,
      REG_OUTER_RADIUS  = 3'd2,
      REG_SOURCE_WIDTH  = 3'd3,
      REG_SOURCE_HEIGHT = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [VIEW_W-1:0]  view_size;
      logic [INNER_W-1:0] inner_radius;
      logic [OUTER_W-1:0] outer_radius;
      logic [SRC_W-1:0]   source_width;
      logic [SRC_W-1:0]   source_height;
   } cfg_type;

   // State of one CORDIC stage.
   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic [ANGLE_BITS-1:0]   angle;
      logic                    axis_hit;
      logic [ANGLE_BITS-1:0]   axis_angle;
   } cordic_type;

   // State of one square root stage; ok marks a pixel in the ring.
   typedef struct packed {
      logic [N_W-1:0]    n;
      logic [ROOT_W-1:0] root;
      logic [N_W-1:0]    sq;
      logic              ok;
   } root_type;

   // Arctangent of 2^-i in units of 2^-32 turn.
   localparam logic [31:0] ATAN_TURN32 [ATAN_LEN] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   // Table entry rounded half up to the angle width.
   function automatic logic [ANGLE_BITS-1:0] atan_entry(input int idx);
      logic [32:0] e;
      e = {1'b0, ATAN_TURN32[idx]} + (33'd1 << (31 - ANGLE_BITS));
      return e[32-ANGLE_BITS +: ANGLE_BITS];
   endfunction

endpackage

// ===== sv/prsm_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for pixel coordinates and mapped results.
// Depend on prsm_pkg for field widths.
interface prsm_req_if;
   import prsm_pkg::*;
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] pixel_x;
   logic [COORD_W-1:0] pixel_y;
   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface prsm_rsp_if;
   import prsm_pkg::*;
   logic             valid;
   logic             ready;
   logic             in_ring;
   logic [OUT_W-1:0] source_column;
   logic [OUT_W-1:0] source_row;
   modport source (output valid, output in_ring, output source_column,
                   output source_row, input ready);
   modport sink (input valid, input in_ring, input source_column,
                 input source_row, output ready);
endinterface

// ===== sv/prsm_front.sv =====
`timescale 1ns / 1ps
// First stage: center offsets, squared distance, ring test and CORDIC setup.
// Depends on prsm_pkg.
module prsm_front (
   input  logic                      clock,
   input  logic                      en,
   input  prsm_pkg::cfg_type         cfg,
   input  logic [prsm_pkg::COORD_W-1:0] pixel_x,
   input  logic [prsm_pkg::COORD_W-1:0] pixel_y,
   output prsm_pkg::cordic_type      cor_out,
   output prsm_pkg::root_type        root_out
);
   import prsm_pkg::*;

   logic [VIEW_W-2:0]         center;
   logic signed [OFS_W-1:0]   east;
   logic signed [OFS_W-1:0]   north;
   logic signed [2*OFS_W-1:0] east2;
   logic signed [2*OFS_W-1:0] north2;
   logic [D2_W:0]             d2_sum;
   logic [D2_W-1:0]           d2;
   logic [2*INNER_W-1:0]      inner2;
   logic [2*OUTER_W-1:0]      outer2;
   logic                      ok;
   logic signed [VEC_W-1:0]   xn;
   logic signed [VEC_W-1:0]   ye;
   cordic_type                cor_in;
   root_type                  root_in;
   cordic_type                cor_ff;
   root_type                  root_ff;

   // Offsets from the view center, east and north positive.
   always_comb begin
      center = cfg.view_size[VIEW_W-1:1];
      east   = $signed({1'b0, pixel_x}) - $signed({1'b0, center});
      north  = $signed({1'b0, center}) - $signed({1'b0, pixel_y});
      east2  = east * east;
      north2 = north * north;
      d2_sum = {1'b0, east2[D2_W-1:0]} + {1'b0, north2[D2_W-1:0]};
      d2     = d2_sum[D2_W-1:0];
      inner2 = cfg.inner_radius * cfg.inner_radius;
      outer2 = cfg.outer_radius * cfg.outer_radius;
   end

   // Ring test, including a setup that draws nothing.
   always_comb begin
      ok = (cfg.view_size != '0) && (cfg.source_width != '0) &&
           (cfg.source_height != '0) &&
           (cfg.outer_radius > {1'b0, cfg.inner_radius}) &&
           ({1'b0, pixel_x} < cfg.view_size) && ({1'b0, pixel_y} < cfg.view_size) &&
           ((2*OUTER_W)'(d2) >= (2*OUTER_W)'(inner2)) &&
           ((2*OUTER_W)'(d2) <= outer2);
   end

   // CORDIC start vector, turned into the northern half plane.
   always_comb begin
      xn = VEC_W'(north) <<< GUARD_BITS;
      ye = VEC_W'(east) <<< GUARD_BITS;
      if (north[OFS_W-1]) begin
         cor_in.x     = -xn;
         cor_in.y     = -ye;
         cor_in.angle = ANGLE_HALF;
      end else begin
         cor_in.x     = xn;
         cor_in.y     = ye;
         cor_in.angle = '0;
      end
      cor_in.axis_hit   = (east == '0) || (north == '0);
      if (east == '0) begin
         cor_in.axis_angle = north[OFS_W-1] ? ANGLE_HALF : '0;
      end else begin
         cor_in.axis_angle = east[OFS_W-1] ? ANGLE_3QUART : ANGLE_QUARTER;
      end
      root_in.n    = {d2, {(2*RADIUS_FRAC_BITS){1'b0}}};
      root_in.root = '0;
      root_in.sq   = '0;
      root_in.ok   = ok;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cor_ff  <= cor_in;
         root_ff <= root_in;
      end
   end

   assign cor_out  = cor_ff;
   assign root_out = root_ff;
endmodule

// ===== sv/prsm_cordic.sv =====
`timescale 1ns / 1ps
// Pipelined CORDIC in vectoring mode, one rotation per stage, giving the
// clockwise angle from north. Depends on prsm_pkg.
module prsm_cordic (
   input  logic                              clock,
   input  logic [prsm_pkg::MID_STAGES-1:0]   en,
   input  prsm_pkg::cordic_type              cor_in,
   output logic [prsm_pkg::ANGLE_BITS-1:0]   angle
);
   import prsm_pkg::*;

   cordic_type stage_ff [MID_STAGES];
   cordic_type last;

   for (genvar s = 0; s < MID_STAGES; s++) begin : g_stage
      cordic_type cur;
      cordic_type stage_in;

      if (s == 0) begin : g_first
         assign cur = cor_in;
      end else begin : g_next
         assign cur = stage_ff[s-1];
      end

      if (s < CORDIC_STEPS) begin : g_iter
         // Rotate toward the x axis; the sign of y picks the direction.
         always_comb begin
            stage_in = cur;
            if (!cur.y[VEC_W-1]) begin
               stage_in.x     = cur.x + ($signed(cur.y) >>> s);
               stage_in.y     = cur.y - ($signed(cur.x) >>> s);
               stage_in.angle = cur.angle + atan_entry(s);
            end else begin
               stage_in.x     = cur.x - ($signed(cur.y) >>> s);
               stage_in.y     = cur.y + ($signed(cur.x) >>> s);
               stage_in.angle = cur.angle - atan_entry(s);
            end
         end
      end else begin : g_pass
         assign stage_in = cur;
      end

      always_ff @(posedge clock) begin
         if (en[s]) begin
            stage_ff[s] <= stage_in;
         end
      end
   end

   // Pixels on an axis take their exact angle.
   assign last  = stage_ff[MID_STAGES-1];
   assign angle = last.axis_hit ? last.axis_angle : last.angle;
endmodule

// ===== sv/prsm_sqrt.sv =====
`timescale 1ns / 1ps
// Pipelined integer square root of the scaled squared radius, one result
// bit per stage from the top; spare stages pass the result on. Depends on prsm_pkg.
module prsm_sqrt (
   input  logic                            clock,
   input  logic [prsm_pkg::MID_STAGES-1:0] en,
   input  prsm_pkg::root_type              root_in,
   output logic [prsm_pkg::ROOT_W-1:0]     root,
   output logic                            ok
);
   import prsm_pkg::*;

   root_type stage_ff [MID_STAGES];

   for (genvar s = 0; s < MID_STAGES; s++) begin : g_stage
      root_type cur;
      root_type stage_in;

      if (s == 0) begin : g_first
         assign cur = root_in;
      end else begin : g_next
         assign cur = stage_ff[s-1];
      end

      if (s < ROOT_W) begin : g_iter
         localparam int K = ROOT_W - 1 - s;
         logic [N_W+1:0] trial_sq;

         // Keep the candidate bit when its square still fits.
         always_comb begin
            trial_sq = {2'b00, cur.sq} + ((N_W + 2)'(cur.root) << (K + 1)) +
                       ((N_W + 2)'(1) << (2 * K));
            stage_in = cur;
            if (trial_sq <= {2'b00, cur.n}) begin
               stage_in.root[K] = 1'b1;
               stage_in.sq      = trial_sq[N_W-1:0];
            end
         end
      end else begin : g_pass
         assign stage_in = cur;
      end

      always_ff @(posedge clock) begin
         if (en[s]) begin
            stage_ff[s] <= stage_in;
         end
      end
   end

   assign root = stage_ff[MID_STAGES-1].root;
   assign ok   = stage_ff[MID_STAGES-1].ok;
endmodule

// ===== sv/prsm_scale.sv =====
`timescale 1ns / 1ps
// Back end: column and row products, pipelined row division, clamps and
// the output register. Depends on prsm_pkg.
module prsm_scale (
   input  logic                              clock,
   input  logic [prsm_pkg::SCALE_STAGES-1:0] en,
   input  prsm_pkg::cfg_type                 cfg,
   input  logic [prsm_pkg::ANGLE_BITS-1:0]   angle,
   input  logic [prsm_pkg::ROOT_W-1:0]       root,
   input  logic                              ok,
   output logic                              in_ring,
   output logic [prsm_pkg::OUT_W-1:0]        source_column,
   output logic [prsm_pkg::OUT_W-1:0]        source_row
);
   import prsm_pkg::*;

   typedef struct packed {
      logic                  ok;
      logic [COL_PROD_W-1:0] col_prod;
      logic [ROW_PROD_W-1:0] row_prod;
   } prod_type;

   typedef struct packed {
      logic                  ok;
      logic [OUT_W-1:0]      col;
      logic                  ovf;
      logic [ROW_PROD_W-1:0] rem;
      logic [QUO_W-1:0]      quo;
   } div_type;

   typedef struct packed {
      logic             ok;
      logic [OUT_W-1:0] col;
      logic [OUT_W-1:0] row;
   } out_type;

   logic [NUM_W-1:0]      num_full;
   logic [NUM_W-1:0]      num;
   logic [SRC_W-1:0]      width_m1;
   logic [SRC_W-1:0]      height_m1;
   logic [OUT_W-1:0]      col_lim;
   logic [OUT_W-1:0]      row_lim;
   logic [OUTER_W-1:0]    span;
   logic [ROW_PROD_W-1:0] den;
   logic [SRC_W-1:0]      col_raw;
   prod_type              prod_in;
   prod_type              prod_ff;
   div_type               div_first;
   div_type               div_ff [QUO_W];
   out_type               out_in;
   out_type               out_ff;

   // Limits and divisor; the user must keep them steady while items are in flight, as the block does not enforce it.
   always_comb begin
      width_m1  = cfg.source_width - SRC_W'(1);
      height_m1 = cfg.source_height - SRC_W'(1);
      col_lim   = (width_m1 > SRC_W'(OUT_MAX)) ? OUT_MAX : width_m1[OUT_W-1:0];
      row_lim   = (height_m1 > SRC_W'(OUT_MAX)) ? OUT_MAX : height_m1[OUT_W-1:0];
      span      = cfg.outer_radius - OUTER_W'(cfg.inner_radius);
      den       = ROW_PROD_W'(span) << RADIUS_FRAC_BITS;
   end

   // Product stage.
   always_comb begin
      num_full         = NUM_W'(cfg.outer_radius) << RADIUS_FRAC_BITS;
      num              = (num_full > NUM_W'(root)) ? num_full - NUM_W'(root) : '0;
      prod_in.ok       = ok;
      prod_in.col_prod = COL_PROD_W'(angle) * COL_PROD_W'(cfg.source_width);
      prod_in.row_prod = ROW_PROD_W'(num) * ROW_PROD_W'(height_m1);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         prod_ff <= prod_in;
      end
   end

   // Column clamp and divider setup; an overflowing quotient clamps later.
   always_comb begin
      col_raw       = prod_ff.col_prod[COL_PROD_W-1 -: SRC_W];
      div_first.ok  = prod_ff.ok;
      div_first.col = (col_raw > SRC_W'(col_lim)) ? col_lim : col_raw[OUT_W-1:0];
      div_first.ovf = ({1'b0, prod_ff.row_prod} >= ((ROW_PROD_W + 1)'(den) << QUO_W));
      div_first.rem = prod_ff.row_prod;
      div_first.quo = '0;
   end

   // Restoring division, one quotient bit per stage.
   for (genvar j = 0; j < QUO_W; j++) begin : g_div
      localparam int B = QUO_W - 1 - j;
      div_type             cur;
      div_type             stage_in;
      logic [ROW_PROD_W:0] dsh;

      if (j == 0) begin : g_first
         assign cur = div_first;
      end else begin : g_next
         assign cur = div_ff[j-1];
      end

      always_comb begin
         dsh      = (ROW_PROD_W + 1)'(den) << B;
         stage_in = cur;
         if ({1'b0, cur.rem} >= dsh) begin
            stage_in.rem    = cur.rem - dsh[ROW_PROD_W-1:0];
            stage_in.quo[B] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (en[j+1]) begin
            div_ff[j] <= stage_in;
         end
      end
   end

   // Row clamp and output register; pixels outside the ring read as zero.
   always_comb begin
      out_in.ok = div_ff[QUO_W-1].ok;
      out_in.col = div_ff[QUO_W-1].ok ? div_ff[QUO_W-1].col : '0;
      if (!div_ff[QUO_W-1].ok) begin
         out_in.row = '0;
      end else if (div_ff[QUO_W-1].ovf || (div_ff[QUO_W-1].quo > row_lim)) begin
         out_in.row = row_lim;
      end else begin
         out_in.row = div_ff[QUO_W-1].quo;
      end
   end

   always_ff @(posedge clock) begin
      if (en[SCALE_STAGES-1]) begin
         out_ff <= out_in;
      end
   end

   assign in_ring       = out_ff.ok;
   assign source_column = out_ff.col;
   assign source_row    = out_ff.row;
endmodule

// ===== sv/polar_ring_source_mapper_unit.sv =====
`timescale 1ns / 1ps
// Polar ring source mapper, top level: register port, stage valid chain.
// Depends on prsm_pkg, prsm_if, prsm_front, prsm_cordic, prsm_sqrt, prsm_scale.
//
// Maps each output pixel of a square polar view to a panorama column and row.
// One word is taken per clock unless a stalled output holds the front stage; it passes through
// one front stage, 16 stages where the CORDIC rotations and the square root bits
// run side by side, a product stage, 12 divider stages for the row and the
// output register. Every stage holds a valid bit and moves on its own, so a
// stalled output only holds the stages that are full and empty slots close
// up behind it. Registers must be written only while no pixel is in flight.
module polar_ring_source_mapper_unit (
   input  logic                           clock,
   input  logic                           reset,
   prsm_req_if.sink                       req,
   prsm_rsp_if.source                     rsp,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [prsm_pkg::ADDR_W-1:0]    paddr,
   input  logic [prsm_pkg::DATA_W-1:0]    pwdata,
   output logic [prsm_pkg::DATA_W-1:0]    prdata,
   output logic                           pready
);
   import prsm_pkg::*;

   cfg_type                 cfg_ff;
   reg_index_type           reg_index;
   logic [TOTAL_STAGES-1:0] valid_ff;
   logic [TOTAL_STAGES-1:0] stage_en;
   cordic_type              cor_start;
   root_type                root_start;
   logic [ANGLE_BITS-1:0]   angle;
   logic [ROOT_W-1:0]       root;
   logic                    ok;

   // Register writes and reads.
   assign pready    = 1'b1;
   assign reg_index = reg_index_type'(paddr[ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.view_size     <= VIEW_W'(512);
         cfg_ff.inner_radius  <= '0;
         cfg_ff.outer_radius  <= OUTER_W'(256);
         cfg_ff.source_width  <= SRC_W'(2048);
         cfg_ff.source_height <= SRC_W'(512);
      end else if (psel && penable && pwrite) begin
         unique case (reg_index)
            REG_VIEW_SIZE:     cfg_ff.view_size     <= pwdata[VIEW_W-1:0];
            REG_INNER_RADIUS:  cfg_ff.inner_radius  <= pwdata[INNER_W-1:0];
            REG_OUTER_RADIUS:  cfg_ff.outer_radius  <= pwdata[OUTER_W-1:0];
            REG_SOURCE_WIDTH:  cfg_ff.source_width  <= pwdata[SRC_W-1:0];
            REG_SOURCE_HEIGHT: cfg_ff.source_height <= pwdata[SRC_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_VIEW_SIZE:     prdata = DATA_W'(cfg_ff.view_size);
         REG_INNER_RADIUS:  prdata = DATA_W'(cfg_ff.inner_radius);
         REG_OUTER_RADIUS:  prdata = DATA_W'(cfg_ff.outer_radius);
         REG_SOURCE_WIDTH:  prdata = DATA_W'(cfg_ff.source_width);
         REG_SOURCE_HEIGHT: prdata = DATA_W'(cfg_ff.source_height);
         default:           prdata = '0;
      endcase
   end

   // A stage loads when it is empty or its content moves on.
   always_comb begin
      stage_en[TOTAL_STAGES-1] = !valid_ff[TOTAL_STAGES-1] || rsp.ready;
      for (int k = TOTAL_STAGES - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < TOTAL_STAGES; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= (k == 0) ? req.valid : valid_ff[k-1];
            end
         end
      end
   end

   assign req.ready = stage_en[0];
   assign rsp.valid = valid_ff[TOTAL_STAGES-1];

   // Datapath.
   prsm_front u_front (
      .clock    (clock),
      .en       (stage_en[0]),
      .cfg      (cfg_ff),
      .pixel_x  (req.pixel_x),
      .pixel_y  (req.pixel_y),
      .cor_out  (cor_start),
      .root_out (root_start)
   );

   prsm_cordic u_cordic (
      .clock  (clock),
      .en     (stage_en[MID_STAGES:1]),
      .cor_in (cor_start),
      .angle  (angle)
   );

   prsm_sqrt u_sqrt (
      .clock   (clock),
      .en      (stage_en[MID_STAGES:1]),
      .root_in (root_start),
      .root    (root),
      .ok      (ok)
   );

   prsm_scale u_scale (
      .clock         (clock),
      .en            (stage_en[TOTAL_STAGES-1:MID_STAGES+1]),
      .cfg           (cfg_ff),
      .angle         (angle),
      .root          (root),
      .ok            (ok),
      .in_ring       (rsp.in_ring),
      .source_column (rsp.source_column),
      .source_row    (rsp.source_row)
   );
endmodule
